### rtl/core/lbs_pkg.sv
// shared types and defaults for the least loaded bin selector
// used by lbs_ctrl, lbs_dp and the top level; no dependencies
package lbs_pkg;

  localparam int DEF_MAX_BINS   = 64;
  localparam int DEF_LOAD_WIDTH = 16;
  localparam int BIN_W          = 7;
  localparam logic [BIN_W-1:0] BINS_RESET = 7'd64;

  // controller to datapath
  typedef struct packed {
    logic clear;   // write zero at the clearing counter and advance it
    logic start;   // transaction accepted, set up the scan
    logic read;    // read the next load entry
    logic commit;  // write back the incremented load and load the output
  } lbs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;  // clearing counter at the last entry
    logic last;      // this read is the final one of the scan
    logic out_free;  // output register can take a result this cycle
  } lbs_status_t;

endpackage

### rtl/core/lbs_ctrl.sv
// sequencing state machine for the least loaded bin selector
// depends on lbs_pkg for the command and status structs
module lbs_ctrl import lbs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  lbs_status_t status,
  output lbs_cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_SETTLE = 5'b01000,
    ST_WRITE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.read = 1'b1;
        if (status.last) begin
          state_next = ST_SETTLE;
        end
      end
      // last read data is compared in this cycle
      ST_SETTLE: begin
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

### rtl/core/lbs_dp.sv
// datapath: load memory, scan and minimum tracking, config and output registers
// depends on lbs_pkg; driven by lbs_ctrl
module lbs_dp import lbs_pkg::*; #(
  parameter int MAX_BINS   = DEF_MAX_BINS,
  parameter int LOAD_WIDTH = DEF_LOAD_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  lbs_cmd_t          cmd,
  output lbs_status_t       status,
  input  logic [BIN_W-1:0]  target_bin,
  input  logic              cfg_we,
  input  logic [BIN_W-1:0]  cfg_wdata,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [BIN_W-1:0]  chosen_bin
);

  localparam int IDX_W   = $clog2(MAX_BINS);
  localparam int NUM_W   = $clog2(MAX_BINS + 1);
  localparam int CNT_W   = (NUM_W > BIN_W) ? NUM_W : BIN_W;
  localparam int SUM_W   = (IDX_W + 1 > BIN_W) ? IDX_W + 1 : BIN_W;
  localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(MAX_BINS - 1);
  localparam logic [CNT_W-1:0] MAX_CNT    = CNT_W'(MAX_BINS);

  logic [LOAD_WIDTH-1:0] mem [MAX_BINS];

  logic [BIN_W-1:0]      bins_in_use;
  logic [IDX_W-1:0]      clr_idx;
  logic [IDX_W-1:0]      scan_idx;
  logic                  named;
  logic                  first_pend;
  logic                  rd_valid;
  logic                  rd_first;
  logic [IDX_W-1:0]      rd_idx;
  logic [LOAD_WIDTH-1:0] rd_data;
  logic [IDX_W-1:0]      best_idx;
  logic [LOAD_WIDTH-1:0] best_load;

  logic [CNT_W-1:0]      cfg_ext;
  logic [CNT_W-1:0]      n_active;
  logic [CNT_W-1:0]      tgt_ext;
  logic                  target_ok;
  logic [IDX_W-1:0]      target_slot;
  logic [IDX_W-1:0]      last_idx;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_wa;
  logic [LOAD_WIDTH-1:0] mem_wd;
  logic [SUM_W-1:0]      bin_num;

  // clamp the active count to 1..MAX_BINS
  always_comb begin
    cfg_ext = CNT_W'(bins_in_use);
    if (cfg_ext == '0) begin
      n_active = CNT_W'(1);
    end else if (cfg_ext > MAX_CNT) begin
      n_active = MAX_CNT;
    end else begin
      n_active = cfg_ext;
    end
    tgt_ext     = CNT_W'(target_bin);
    target_ok   = (tgt_ext != '0) && (tgt_ext <= n_active);
    target_slot = IDX_W'(tgt_ext - CNT_W'(1));
    last_idx    = IDX_W'(n_active - CNT_W'(1));
  end

  assign status.clr_last = (clr_idx == LAST_ENTRY);
  assign status.last     = named || (scan_idx == last_idx);
  assign status.out_free = !out_valid || out_ready;

  always_comb begin
    mem_we = cmd.clear || cmd.commit;
    mem_wa = cmd.clear ? clr_idx : best_idx;
    if (cmd.clear) begin
      mem_wd = '0;
    end else if (best_load == '1) begin
      mem_wd = best_load;  // saturated
    end else begin
      mem_wd = best_load + LOAD_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bins_in_use <= BINS_RESET;
      clr_idx     <= '0;
      first_pend  <= 1'b0;
      rd_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        bins_in_use <= cfg_wdata;
      end
      if (cmd.clear) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
      if (cmd.start) begin
        first_pend <= 1'b1;
      end else if (cmd.read) begin
        first_pend <= 1'b0;
      end
      rd_valid <= cmd.read;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign bin_num = SUM_W'(best_idx) + SUM_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      named    <= target_ok;
      scan_idx <= target_ok ? target_slot : '0;
    end else if (cmd.read) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    rd_first <= first_pend;
    rd_idx   <= scan_idx;
    // strict compare keeps the lowest index on a tie
    if (rd_valid && (rd_first || (rd_data < best_load))) begin
      best_load <= rd_data;
      best_idx  <= rd_idx;
    end
    if (cmd.commit) begin
      chosen_bin <= bin_num[BIN_W-1:0];
    end
  end

endmodule

### rtl/core/least_loaded_bin_selector.sv
// Least loaded bin selector. Each request names a bin (1..active count) or
// gives zero or any out-of-range value for automatic choice, which picks the
// active bin with the smallest load, lowest index on a tie; the chosen bin's
// load rises by one, saturating, and its number is returned. Loads sit in a
// memory with one write and one read port that is read one entry per cycle
// during a scan; a named request reads only its own entry, an automatic one
// reads every active entry. After reset a clearing pass zeroes every load
// entry; in_ready stays low until it ends. A new transaction may be taken
// while the previous result waits in the output register.
// depends on lbs_pkg, lbs_ctrl and lbs_dp
module least_loaded_bin_selector import lbs_pkg::*; #(
  parameter int MAX_BINS   = DEF_MAX_BINS,
  parameter int LOAD_WIDTH = DEF_LOAD_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [BIN_W-1:0] target_bin,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [BIN_W-1:0] chosen_bin,
  input  logic             cfg_we,
  input  logic [BIN_W-1:0] cfg_wdata
);

  lbs_cmd_t    cmd;
  lbs_status_t status;

  lbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lbs_dp #(
    .MAX_BINS   (MAX_BINS),
    .LOAD_WIDTH (LOAD_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .target_bin (target_bin),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .chosen_bin (chosen_bin)
  );

endmodule

### rtl/core/lbs_checker.sv
// port-level checks for least_loaded_bin_selector, bound to the top level
// depends on lbs_pkg
module lbs_checker import lbs_pkg::*; #(
  parameter int MAX_BINS = DEF_MAX_BINS
) (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [BIN_W-1:0] chosen_bin
);

  // held result keeps its value until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(chosen_bin))
    else $error("result changed or dropped while stalled");

  // loads are being cleared straight after reset
  a_no_accept_in_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("ready during or right after reset");

  // one transaction in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken before the first was resolved");

  // bin numbers are one-based while they fit the field
  a_bin_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (MAX_BINS >= 128) || (chosen_bin != '0))
    else $error("bin number zero returned");

endmodule

bind least_loaded_bin_selector lbs_checker #(
  .MAX_BINS (MAX_BINS)
) u_lbs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .chosen_bin (chosen_bin)
);

### test/tb_top.sv
// self-checking testbench for least_loaded_bin_selector: directed table, then random phases
// predicts each chosen bin from its own load table; depends on lbs_pkg and the rtl top level
`timescale 1ns / 1ps

module tb_top;
  import lbs_pkg::*;

  localparam int NBINS          = DEF_MAX_BINS;
  localparam int LOAD_W         = DEF_LOAD_WIDTH;
  localparam logic [LOAD_W-1:0] LOAD_TOP = '1;
  localparam logic [BIN_W-1:0]  BIN_AUTO = '0;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = NBINS + 16;
  localparam int REPORT_LIMIT   = 10;
  localparam int NUM_PHASES     = 12;
  localparam int PHASE_ITEMS    = 104;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [BIN_W-1:0] value;
    logic             typed;
    logic [BIN_W-1:0] want;
  } dir_row_t;

  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{ROW_REQ, 7'd0,   1'b1, 7'd1},   // fresh loads, first bin wins
    '{ROW_REQ, 7'd0,   1'b1, 7'd2},
    '{ROW_REQ, 7'd64,  1'b1, 7'd64},  // top bin named
    '{ROW_REQ, 7'd1,   1'b1, 7'd1},
    '{ROW_REQ, 7'd127, 1'b0, 7'd0},   // beyond range, automatic
    '{ROW_REQ, 7'd65,  1'b0, 7'd0},
    '{ROW_CFG, 7'd0,   1'b0, 7'd0},   // zero bins acts as one
    '{ROW_REQ, 7'd0,   1'b1, 7'd1},
    '{ROW_REQ, 7'd5,   1'b1, 7'd1},
    '{ROW_REQ, 7'd1,   1'b1, 7'd1},
    '{ROW_CFG, 7'd127, 1'b0, 7'd0},   // clamps to the maximum
    '{ROW_REQ, 7'd64,  1'b1, 7'd64},
    '{ROW_REQ, 7'd0,   1'b0, 7'd0},
    '{ROW_CFG, 7'd1,   1'b0, 7'd0},
    '{ROW_REQ, 7'd2,   1'b1, 7'd1},
    '{ROW_CFG, 7'd3,   1'b0, 7'd0},
    '{ROW_REQ, 7'd0,   1'b0, 7'd0},
    '{ROW_REQ, 7'd3,   1'b1, 7'd3},
    '{ROW_REQ, 7'd4,   1'b0, 7'd0},
    '{ROW_CFG, 7'd64,  1'b0, 7'd0},   // hidden bins rejoin with their old loads
    '{ROW_REQ, 7'd0,   1'b0, 7'd0},
    '{ROW_REQ, 7'd42,  1'b1, 7'd42},
    '{ROW_REQ, 7'd85,  1'b0, 7'd0},
    '{ROW_REQ, 7'd42,  1'b1, 7'd42}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [BIN_W-1:0] target_bin = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [BIN_W-1:0] chosen_bin;
  logic             cfg_we = 1'b0;
  logic [BIN_W-1:0] cfg_wdata = '0;

  // typed expectation travels with the transaction it belongs to
  logic             typed_chk = 1'b0;
  logic [BIN_W-1:0] typed_bin = '0;

  logic [LOAD_W-1:0] bin_count [NBINS];
  logic [BIN_W-1:0]  bins_setting;
  logic [BIN_W-1:0]  pending_bins [$];
  int                mismatch_cnt = 0;
  int                idle_cycles = 0;
  int                stall_hold = 0;
  logic              gaps_on = 1'b0;
  logic              stall_on = 1'b0;

  least_loaded_bin_selector #(
    .MAX_BINS  (NBINS),
    .LOAD_WIDTH(LOAD_W)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .target_bin(target_bin),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .chosen_bin(chosen_bin),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int active_bins();
    int n;
    n = bins_setting;
    if (n < 1) n = 1;
    if (n > NBINS) n = NBINS;
    return n;
  endfunction

  // picks the bin for one request and bumps its load
  function automatic logic [BIN_W-1:0] route_request(input logic [BIN_W-1:0] tgt);
    int n;
    int slot;
    n = active_bins();
    if (tgt >= 1 && tgt <= n) begin
      slot = tgt - 1;
    end else begin
      slot = 0;
      for (int k = 1; k < n; k++) begin
        if (bin_count[k] < bin_count[slot]) slot = k;
      end
    end
    if (bin_count[slot] != LOAD_TOP) bin_count[slot] = bin_count[slot] + 1'b1;
    return BIN_W'(slot + 1);
  endfunction

  initial begin
    for (int k = 0; k < NBINS; k++) bin_count[k] = '0;
    bins_setting = BINS_RESET;
  end

  // prediction on accepted transactions and register writes
  always @(posedge clk) begin
    logic [BIN_W-1:0] pred;
    if (!rst) begin
      if (cfg_we) bins_setting = cfg_wdata;
      if (in_valid && in_ready) begin
        pred = route_request(target_bin);
        pending_bins.push_back(typed_chk ? typed_bin : pred);
      end
    end
  end

  // result checking
  always @(posedge clk) begin
    logic [BIN_W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (pending_bins.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_LIMIT)
          $display("unexpected result: chosen_bin %0d with nothing outstanding", chosen_bin);
      end else begin
        want = pending_bins.pop_front();
        if (chosen_bin !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_LIMIT)
            $display("chosen_bin mismatch: expected %0d, got %0d", want, chosen_bin);
        end
      end
    end
  end

  // receiver back-pressure in bursts
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
      if (stall_hold == 1) out_ready <= 1'b1;
    end else if (stall_on && $urandom_range(0, 11) == 0) begin
      out_ready <= 1'b0;
      stall_hold <= $urandom_range(1, 18);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_req(input logic [BIN_W-1:0] tgt, input logic chk,
                          input logic [BIN_W-1:0] want);
    in_valid  <= 1'b1;
    target_bin <= tgt;
    typed_chk <= chk;
    typed_bin <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic sender_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // only written with the block drained
  task automatic write_bins(input logic [BIN_W-1:0] value);
    in_valid <= 1'b0;
    // let the last acceptance reach the queue first
    @(posedge clk);
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [BIN_W-1:0] random_target();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return BIN_AUTO;
    if (r < 8) return BIN_W'($urandom_range(1, active_bins()));
    return BIN_W'($urandom_range(0, 127));
  endfunction

  function automatic logic [BIN_W-1:0] phase_setting(input int phase);
    case (phase)
      0: return 7'd1;
      1: return 7'd64;
      2: return 7'd0;
      3: return 7'd127;
      4: return 7'd2;
      default: begin
        if ($urandom_range(0, 1) == 0) return BIN_W'($urandom_range(1, 8));
        return BIN_W'($urandom_range(0, 127));
      end
    endcase
  endfunction

  initial begin
    logic quiet;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    gaps_on  = 1'b1;
    stall_on = 1'b1;
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TABLE[i].kind == ROW_CFG) begin
        write_bins(DIR_TABLE[i].value);
      end else begin
        send_req(DIR_TABLE[i].value, DIR_TABLE[i].typed, DIR_TABLE[i].want);
        sender_gap();
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      quiet = (p >= NUM_PHASES - 2);
      write_bins(phase_setting(p));
      gaps_on  = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
      stall_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_req(random_target(), 1'b0, BIN_AUTO);
        sender_gap();
      end
    end

    in_valid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_bins.size() != 0) begin
      mismatch_cnt++;
      $display("%0d results never arrived", pending_bins.size());
    end
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### least_loaded_bin_selector.f
rtl/core/lbs_pkg.sv
rtl/core/lbs_ctrl.sv
rtl/core/lbs_dp.sv
rtl/core/least_loaded_bin_selector.sv
rtl/core/lbs_checker.sv
test/tb_top.sv
